/* rtl/core/lru_arena_cache_controller_assert.svh */
// Assertion macros for the arena cache controller checkers.
`ifndef LRU_ARENA_CACHE_CONTROLLER_ASSERT_SVH
`define LRU_ARENA_CACHE_CONTROLLER_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define LAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/lac_pkg.sv */
// Package: constants, types and helpers of the arena cache controller.
`timescale 1ns / 1ps
package lac_pkg;

  localparam int ENTRIES      = 32;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int CNT_W        = $clog2(ENTRIES + 1);
  localparam int BUDGET_BYTES = 4096;

  localparam int KEY_W  = 25;
  localparam int SRC_W  = 32;
  localparam int NEED_W = 16;
  localparam int OFF_W  = 12;
  localparam int SIZE_W = 13;
  localparam int AGE_W  = 16;
  localparam int FILL_W = 13;
  localparam int TOT_W  = 32;
  localparam int SUM_W  = NEED_W + 1;

  localparam logic [AGE_W-1:0] OLDEST_START = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_LOAD   = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef struct packed {
    logic             wr_key;
    logic             wr_off;
    logic             wr_size;
    logic             wr_age;
    logic             set_valid;
    logic             clr_valid;
    logic             clr_all;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } store_wr_t;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  slot;
    logic [OFF_W-1:0]  entry_offset;
    logic [SIZE_W-1:0] entry_bytes;
    logic [SRC_W-1:0]  fetch_source;
    logic              compacted;
    logic              cleared;
    logic [FILL_W-1:0] arena_used;
    logic [TOT_W-1:0]  hit_total;
    logic [TOT_W-1:0]  miss_total;
    logic [TOT_W-1:0]  evict_total;
  } rsp_t;

  // True when need more bytes still fit behind fill.
  function automatic logic fits_fn(input logic [FILL_W-1:0] fill,
                                   input logic [NEED_W-1:0] need);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(fill) + SUM_W'(need);
    return sum <= SUM_W'(BUDGET_BYTES);
  endfunction

endpackage

/* rtl/core/lac_if.sv */
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface lac_req_if;
  logic                       valid;
  logic                       ready;
  logic [lac_pkg::KEY_W-1:0]  key;
  logic [lac_pkg::SRC_W-1:0]  source_offset;
  logic [lac_pkg::NEED_W-1:0] byte_count;

  modport source (output valid, key, source_offset, byte_count, input ready);
  modport sink (input valid, key, source_offset, byte_count, output ready);
endinterface

interface lac_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [lac_pkg::IDX_W-1:0]  slot;
  logic [lac_pkg::OFF_W-1:0]  entry_offset;
  logic [lac_pkg::SIZE_W-1:0] entry_bytes;
  logic [lac_pkg::SRC_W-1:0]  fetch_source;
  logic                       compacted;
  logic                       cleared;
  logic [lac_pkg::FILL_W-1:0] arena_used;
  logic [lac_pkg::TOT_W-1:0]  hit_total;
  logic [lac_pkg::TOT_W-1:0]  miss_total;
  logic [lac_pkg::TOT_W-1:0]  evict_total;

  modport source (output valid, status, slot, entry_offset, entry_bytes, fetch_source,
                  compacted, cleared, arena_used, hit_total, miss_total, evict_total,
                  input ready);
  modport sink (input valid, status, slot, entry_offset, entry_bytes, fetch_source,
                compacted, cleared, arena_used, hit_total, miss_total, evict_total,
                output ready);
endinterface

/* rtl/core/lru_arena_cache_controller.sv */
// Top level of the fully associative LRU cache controller with a byte arena.
`timescale 1ns / 1ps
// Takes one request at a time: a request is accepted only while the
// sequencer is idle, and the result sits in an output register, so the next
// request can enter while that result still waits. Each request first scans
// all 32 slots, one per cycle, through a single read port of the entry
// table. A load into a free slot then takes a fit check and a commit.
// Evicting to free a slot takes a full age scan plus the invalidate; each
// eviction that makes room in the arena takes another fit check, the age
// scan and the invalidate, and each repack of the live entries is another
// full table scan. The arena is a bump allocator: offsets only grow until
// entries are evicted and the live ones are repacked in slot order, or the
// table is cleared outright when nothing is left to evict. Hit, miss and
// eviction totals wrap at 32 bits.
module lru_arena_cache_controller (
  input logic     clk_i,
  input logic     rst_ni,
  lac_req_if.sink   req_i,
  lac_rsp_if.source rsp_o
);

  lac_pkg::store_wr_t        wr;
  logic [lac_pkg::IDX_W-1:0] rd_idx;
  lac_pkg::entry_t           rd_entry;
  logic                      rd_valid;
  lac_pkg::rsp_t             rsp;
  logic                      req_ready;
  logic                      rsp_valid;

  // Entry table; one write and one read a cycle.
  lac_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid)
  );

  // Lookup, eviction, repack and allocation sequencer.
  lac_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .req_key_i   (req_i.key),
    .req_src_i   (req_i.source_offset),
    .req_need_i  (req_i.byte_count),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp),
    .wr_o        (wr),
    .rd_idx_o    (rd_idx),
    .rd_entry_i  (rd_entry),
    .rd_valid_i  (rd_valid)
  );

  assign req_i.ready        = req_ready;
  assign rsp_o.valid        = rsp_valid;
  assign rsp_o.status       = rsp.status;
  assign rsp_o.slot         = rsp.slot;
  assign rsp_o.entry_offset = rsp.entry_offset;
  assign rsp_o.entry_bytes  = rsp.entry_bytes;
  assign rsp_o.fetch_source = rsp.fetch_source;
  assign rsp_o.compacted    = rsp.compacted;
  assign rsp_o.cleared      = rsp.cleared;
  assign rsp_o.arena_used   = rsp.arena_used;
  assign rsp_o.hit_total    = rsp.hit_total;
  assign rsp_o.miss_total   = rsp.miss_total;
  assign rsp_o.evict_total  = rsp.evict_total;

endmodule

/* rtl/core/lac_store.sv */
// Entry table: key, offset, size and age per slot, with valid bits.
`timescale 1ns / 1ps
module lac_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lac_pkg::store_wr_t        wr_i,
  input  logic [lac_pkg::IDX_W-1:0] rd_idx_i,
  output lac_pkg::entry_t           rd_entry_o,
  output logic                      rd_valid_o
);

  lac_pkg::entry_t                entry_q [lac_pkg::ENTRIES];
  logic [lac_pkg::ENTRIES-1:0]    valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_key)  entry_q[wr_i.idx].key  <= wr_i.data.key;
    if (wr_i.wr_off)  entry_q[wr_i.idx].off  <= wr_i.data.off;
    if (wr_i.wr_size) entry_q[wr_i.idx].size <= wr_i.data.size;
    if (wr_i.wr_age)  entry_q[wr_i.idx].age  <= wr_i.data.age;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.clr_all) begin
      valid_q <= '0;
    end else if (wr_i.set_valid) begin
      valid_q[wr_i.idx] <= 1'b1;
    end else if (wr_i.clr_valid) begin
      valid_q[wr_i.idx] <= 1'b0;
    end
  end

  assign rd_entry_o = entry_q[rd_idx_i];
  assign rd_valid_o = valid_q[rd_idx_i];

endmodule

/* rtl/core/lac_seq.sv */
// Sequencer: scans the table one slot a cycle for lookup, eviction and repacking.
`timescale 1ns / 1ps
module lac_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  logic [lac_pkg::KEY_W-1:0]  req_key_i,
  input  logic [lac_pkg::SRC_W-1:0]  req_src_i,
  input  logic [lac_pkg::NEED_W-1:0] req_need_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output lac_pkg::rsp_t              rsp_o,
  output lac_pkg::store_wr_t         wr_o,
  output logic [lac_pkg::IDX_W-1:0]  rd_idx_o,
  input  lac_pkg::entry_t            rd_entry_i,
  input  logic                       rd_valid_i
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOOK   = 8'b0000_0010,
    S_EVSCAN = 8'b0000_0100,
    S_EVDONE = 8'b0000_1000,
    S_FIT    = 8'b0001_0000,
    S_PACK   = 8'b0010_0000,
    S_COMMIT = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e                       state_q, state_d;
  logic [lac_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [lac_pkg::KEY_W-1:0]    key_q, key_d;
  logic [lac_pkg::SRC_W-1:0]    src_q, src_d;
  logic [lac_pkg::NEED_W-1:0]   need_q, need_d;
  logic                         hit_q, hit_d;
  logic                         free_q, free_d;
  logic [lac_pkg::IDX_W-1:0]    free_idx_q, free_idx_d;
  logic [lac_pkg::IDX_W-1:0]    slot_q, slot_d;
  logic [lac_pkg::AGE_W-1:0]    best_q, best_d;
  logic [lac_pkg::IDX_W-1:0]    pick_q, pick_d;
  logic                         for_slot_q, for_slot_d;
  logic [lac_pkg::FILL_W-1:0]   pos_q, pos_d;
  logic [lac_pkg::CNT_W-1:0]    live_q, live_d;
  logic [lac_pkg::FILL_W-1:0]   fill_q, fill_d;
  logic [lac_pkg::AGE_W-1:0]    age_clk_q, age_clk_d;
  logic [lac_pkg::TOT_W-1:0]    hits_q, hits_d;
  logic [lac_pkg::TOT_W-1:0]    misses_q, misses_d;
  logic [lac_pkg::TOT_W-1:0]    evicts_q, evicts_d;
  lac_pkg::status_e             res_status_q, res_status_d;
  logic [lac_pkg::OFF_W-1:0]    res_off_q, res_off_d;
  logic [lac_pkg::SIZE_W-1:0]   res_bytes_q, res_bytes_d;
  logic                         packed_q, packed_d;
  logic                         wiped_q, wiped_d;
  logic                         out_v_q, out_v_d;
  lac_pkg::rsp_t                out_q, out_d;

  logic                         last;
  logic                         match;
  logic                         hit_now;
  logic                         free_now;
  logic [lac_pkg::IDX_W-1:0]    hit_idx;
  logic [lac_pkg::IDX_W-1:0]    free_now_idx;
  logic [lac_pkg::FILL_W-1:0]   fill_now;
  logic [lac_pkg::FILL_W-1:0]   pos_now;
  logic                         bad_size;

  assign last     = (idx_q == lac_pkg::IDX_W'(lac_pkg::ENTRIES - 1));
  assign match    = rd_valid_i && (rd_entry_i.key == key_q);
  assign bad_size = (need_q == '0) || (need_q > lac_pkg::NEED_W'(lac_pkg::BUDGET_BYTES));
  assign rd_idx_o = idx_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    key_d        = key_q;
    src_d        = src_q;
    need_d       = need_q;
    hit_d        = hit_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    slot_d       = slot_q;
    best_d       = best_q;
    pick_d       = pick_q;
    for_slot_d   = for_slot_q;
    pos_d        = pos_q;
    live_d       = live_q;
    fill_d       = fill_q;
    age_clk_d    = age_clk_q;
    hits_d       = hits_q;
    misses_d     = misses_q;
    evicts_d     = evicts_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    res_bytes_d  = res_bytes_q;
    packed_d     = packed_q;
    wiped_d      = wiped_q;
    out_v_d      = out_v_q;
    out_d        = out_q;
    wr_o         = '0;
    req_ready_o  = 1'b0;
    hit_now      = hit_q || match;
    hit_idx      = hit_q ? slot_q : idx_q;
    free_now     = free_q || !rd_valid_i;
    free_now_idx = free_q ? free_idx_q : idx_q;
    fill_now     = fill_q;
    pos_now      = pos_q + lac_pkg::FILL_W'(rd_entry_i.size);

    if (out_v_q && rsp_ready_i) out_v_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          key_d    = req_key_i;
          src_d    = req_src_i;
          need_d   = req_need_i;
          idx_d    = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          packed_d = 1'b0;
          wiped_d  = 1'b0;
          state_d  = S_LOOK;
        end
      end

      S_LOOK: begin
        if (match && !hit_q) begin
          hit_d       = 1'b1;
          slot_d      = idx_q;
          res_off_d   = rd_entry_i.off;
          res_bytes_d = rd_entry_i.size;
        end
        if (!rd_valid_i && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = idx_q;
        end
        idx_d = idx_q + 1'b1;
        if (last) begin
          idx_d = '0;
          if (hit_now) begin
            // Refresh the age of the hit entry.
            hits_d          = hits_q + 1'b1;
            age_clk_d       = age_clk_q + 1'b1;
            wr_o.wr_age     = 1'b1;
            wr_o.idx        = hit_idx;
            wr_o.data.age   = age_clk_d;
            res_status_d    = lac_pkg::ST_HIT;
            state_d         = S_FINISH;
          end else begin
            misses_d = misses_q + 1'b1;
            if (bad_size) begin
              res_status_d = lac_pkg::ST_REJECT;
              slot_d       = '0;
              res_off_d    = '0;
              res_bytes_d  = '0;
              state_d      = S_FINISH;
            end else if (free_now) begin
              slot_d  = free_now_idx;
              state_d = S_FIT;
            end else begin
              for_slot_d = 1'b1;
              best_d     = lac_pkg::OLDEST_START;
              state_d    = S_EVSCAN;
            end
          end
        end
      end

      S_EVSCAN: begin
        // Smallest age wins; ties go to the later slot.
        if (rd_valid_i && (rd_entry_i.age <= best_q)) begin
          best_d = rd_entry_i.age;
          pick_d = idx_q;
        end
        idx_d = idx_q + 1'b1;
        if (last) begin
          idx_d   = '0;
          state_d = S_EVDONE;
        end
      end

      S_EVDONE: begin
        wr_o.clr_valid = 1'b1;
        wr_o.idx       = pick_q;
        evicts_d       = evicts_q + 1'b1;
        live_d         = live_q - 1'b1;
        if (live_q == lac_pkg::CNT_W'(1)) fill_now = '0;
        fill_d = fill_now;
        if (for_slot_q) begin
          for_slot_d = 1'b0;
          slot_d     = pick_q;
          state_d    = S_FIT;
        end else if (!lac_pkg::fits_fn(fill_now, need_q)) begin
          pos_d   = '0;
          state_d = S_PACK;
        end else begin
          state_d = S_FIT;
        end
      end

      S_PACK: begin
        if (rd_valid_i) begin
          wr_o.wr_off   = 1'b1;
          wr_o.idx      = idx_q;
          wr_o.data.off = pos_q[lac_pkg::OFF_W-1:0];
          pos_d         = pos_now;
        end
        idx_d = idx_q + 1'b1;
        if (last) begin
          idx_d    = '0;
          fill_d   = rd_valid_i ? pos_now : pos_q;
          packed_d = 1'b1;
          state_d  = S_FIT;
        end
      end

      S_FIT: begin
        if (lac_pkg::fits_fn(fill_q, need_q)) begin
          state_d = S_COMMIT;
        end else if (live_q == '0) begin
          wr_o.clr_all = 1'b1;
          fill_d       = '0;
          wiped_d      = 1'b1;
          state_d      = S_COMMIT;
        end else begin
          best_d  = lac_pkg::OLDEST_START;
          idx_d   = '0;
          state_d = S_EVSCAN;
        end
      end

      S_COMMIT: begin
        age_clk_d      = age_clk_q + 1'b1;
        wr_o.wr_key    = 1'b1;
        wr_o.wr_off    = 1'b1;
        wr_o.wr_size   = 1'b1;
        wr_o.wr_age    = 1'b1;
        wr_o.set_valid = 1'b1;
        wr_o.idx       = slot_q;
        wr_o.data.key  = key_q;
        wr_o.data.off  = fill_q[lac_pkg::OFF_W-1:0];
        wr_o.data.size = need_q[lac_pkg::SIZE_W-1:0];
        wr_o.data.age  = age_clk_d;
        live_d         = live_q + 1'b1;
        fill_d         = fill_q + need_q[lac_pkg::FILL_W-1:0];
        res_status_d   = lac_pkg::ST_LOAD;
        res_off_d      = fill_q[lac_pkg::OFF_W-1:0];
        res_bytes_d    = need_q[lac_pkg::SIZE_W-1:0];
        state_d        = S_FINISH;
      end

      S_FINISH: begin
        // Load the output register once it is free.
        if (!out_v_q || rsp_ready_i) begin
          out_v_d            = 1'b1;
          out_d.status       = res_status_q;
          out_d.slot         = slot_q;
          out_d.entry_offset = res_off_q;
          out_d.entry_bytes  = res_bytes_q;
          out_d.fetch_source = (res_status_q == lac_pkg::ST_LOAD) ? src_q : '0;
          out_d.compacted    = packed_q;
          out_d.cleared      = wiped_q;
          out_d.arena_used   = fill_q;
          out_d.hit_total    = hits_q;
          out_d.miss_total   = misses_q;
          out_d.evict_total  = evicts_q;
          state_d            = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      live_q    <= '0;
      fill_q    <= '0;
      age_clk_q <= lac_pkg::AGE_W'(1);
      hits_q    <= '0;
      misses_q  <= '0;
      evicts_q  <= '0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      live_q    <= live_d;
      fill_q    <= fill_d;
      age_clk_q <= age_clk_d;
      hits_q    <= hits_d;
      misses_q  <= misses_d;
      evicts_q  <= evicts_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    src_q        <= src_d;
    need_q       <= need_d;
    hit_q        <= hit_d;
    free_q       <= free_d;
    free_idx_q   <= free_idx_d;
    slot_q       <= slot_d;
    best_q       <= best_d;
    pick_q       <= pick_d;
    for_slot_q   <= for_slot_d;
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    res_bytes_q  <= res_bytes_d;
    packed_q     <= packed_d;
    wiped_q      <= wiped_d;
    out_q        <= out_d;
  end

  assign rsp_valid_o = out_v_q;
  assign rsp_o       = out_q;

endmodule

/* rtl/core/lac_checker.sv */
// Port-level checker for the arena cache controller, bound to the top level.
`timescale 1ns / 1ps
`include "lru_arena_cache_controller_assert.svh"
module lac_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [1:0]                 rsp_status_i,
  input logic [lac_pkg::SRC_W-1:0]  rsp_fetch_i,
  input logic                       rsp_compacted_i,
  input logic                       rsp_cleared_i,
  input logic [lac_pkg::FILL_W-1:0] rsp_used_i
);

  logic status_ok;
  logic is_hit;
  logic hit_quiet;
  logic used_ok;

  assign status_ok = (rsp_status_i == lac_pkg::ST_HIT) || (rsp_status_i == lac_pkg::ST_LOAD) ||
                     (rsp_status_i == lac_pkg::ST_REJECT);
  assign is_hit    = (rsp_status_i == lac_pkg::ST_HIT);
  assign hit_quiet = (rsp_fetch_i == '0) && !rsp_compacted_i && !rsp_cleared_i;
  assign used_ok   = (rsp_used_i <= lac_pkg::FILL_W'(lac_pkg::BUDGET_BYTES));

  `LAC_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "response dropped")
  `LAC_ASSERT(a_busy_after_accept, req_valid_i && req_ready_i |=> !req_ready_i, "accepted twice")
  `LAC_ASSERT(a_status_legal, rsp_valid_i |-> status_ok, "illegal status")
  `LAC_ASSERT(a_hit_quiet, rsp_valid_i && is_hit |-> hit_quiet, "hit with side effects")
  `LAC_ASSERT(a_budget, rsp_valid_i |-> used_ok, "arena over budget")

endmodule

bind lru_arena_cache_controller lac_checker u_lac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_status_i    (rsp_o.status),
  .rsp_fetch_i     (rsp_o.fetch_source),
  .rsp_compacted_i (rsp_o.compacted),
  .rsp_cleared_i   (rsp_o.cleared),
  .rsp_used_i      (rsp_o.arena_used)
);

/* sim/tb.sv */
// Testbench for the LRU arena cache controller: requests checked against a local predictor.
`timescale 1ns / 1ps
module tb;

  logic clk;
  logic rst_n;

  lac_req_if req ();
  lac_rsp_if rsp ();

  lru_arena_cache_controller DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Shadow of the cache table and arena.
  logic [lac_pkg::KEY_W-1:0]  tbl_key   [lac_pkg::ENTRIES];
  logic                       tbl_valid [lac_pkg::ENTRIES];
  logic [lac_pkg::OFF_W-1:0]  tbl_off   [lac_pkg::ENTRIES];
  logic [lac_pkg::SIZE_W-1:0] tbl_size  [lac_pkg::ENTRIES];
  logic [lac_pkg::AGE_W-1:0]  tbl_age   [lac_pkg::ENTRIES];
  logic [lac_pkg::FILL_W-1:0] fill;
  logic [lac_pkg::AGE_W-1:0]  age_now;
  logic [lac_pkg::TOT_W-1:0]  hits, misses, evicts;

  lac_pkg::rsp_t pending_rsp[$];
  logic [lac_pkg::KEY_W-1:0] recent_keys[$];
  int err_cnt;
  int idle_pct;
  int stall_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Evict the least recent entry, ties to the highest slot; -1 when empty.
  function automatic int drop_oldest();
    int pick;
    logic [lac_pkg::AGE_W:0] best;
    bit any;
    pick = -1;
    best = {1'b0, lac_pkg::OLDEST_START};
    any = 1'b0;
    for (int i = 0; i < lac_pkg::ENTRIES; i++) begin
      if (tbl_valid[i] && {1'b0, tbl_age[i]} <= best) begin
        best = {1'b0, tbl_age[i]};
        pick = i;
      end
    end
    if (pick < 0) return -1;
    tbl_valid[pick] = 1'b0;
    evicts++;
    for (int i = 0; i < lac_pkg::ENTRIES; i++) if (tbl_valid[i]) any = 1'b1;
    if (!any) fill = '0;
    return pick;
  endfunction

  // Work out the response to one lookup and advance the shadow state.
  function automatic lac_pkg::rsp_t predict_lookup(logic [lac_pkg::KEY_W-1:0] key,
                                                   logic [lac_pkg::SRC_W-1:0] src,
                                                   logic [lac_pkg::NEED_W-1:0] need);
    lac_pkg::rsp_t r;
    int hit;
    int slot;
    int pos;
    hit = -1;
    r = '0;
    for (int i = 0; i < lac_pkg::ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key) begin
        hit = i;
        break;
      end
    end
    if (hit >= 0) begin
      hits++;
      age_now++;
      tbl_age[hit] = age_now;
      r.status = lac_pkg::ST_HIT;
      r.slot = lac_pkg::IDX_W'(hit);
      r.entry_offset = tbl_off[hit];
      r.entry_bytes = tbl_size[hit];
    end else begin
      misses++;
      if (need == 0 || need > lac_pkg::BUDGET_BYTES) begin
        r.status = lac_pkg::ST_REJECT;
      end else begin
        slot = -1;
        for (int i = 0; i < lac_pkg::ENTRIES; i++) begin
          if (!tbl_valid[i]) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) slot = drop_oldest();
        if (slot < 0) slot = 0;
        while (int'(fill) + int'(need) > lac_pkg::BUDGET_BYTES) begin
          if (drop_oldest() < 0) begin
            for (int i = 0; i < lac_pkg::ENTRIES; i++) begin
              tbl_key[i] = '0; tbl_valid[i] = 1'b0; tbl_off[i] = '0;
              tbl_size[i] = '0; tbl_age[i] = '0;
            end
            fill = '0;
            r.cleared = 1'b1;
            break;
          end
          if (int'(fill) + int'(need) > lac_pkg::BUDGET_BYTES) begin
            // repack live entries in slot order
            pos = 0;
            for (int i = 0; i < lac_pkg::ENTRIES; i++) begin
              if (!tbl_valid[i]) continue;
              tbl_off[i] = lac_pkg::OFF_W'(pos);
              pos += tbl_size[i];
            end
            fill = lac_pkg::FILL_W'(pos);
            r.compacted = 1'b1;
          end
        end
        r.entry_offset = fill[lac_pkg::OFF_W-1:0];
        fill = fill + lac_pkg::FILL_W'(need);
        age_now++;
        tbl_key[slot] = key;
        tbl_size[slot] = need[lac_pkg::SIZE_W-1:0];
        tbl_off[slot] = r.entry_offset;
        tbl_age[slot] = age_now;
        tbl_valid[slot] = 1'b1;
        r.status = lac_pkg::ST_LOAD;
        r.slot = lac_pkg::IDX_W'(slot);
        r.entry_bytes = need[lac_pkg::SIZE_W-1:0];
        r.fetch_source = src;
      end
    end
    r.arena_used = fill;
    r.hit_total = hits;
    r.miss_total = misses;
    r.evict_total = evicts;
    return r;
  endfunction

  // Offer one item, hold it until accepted, then record what it must produce.
  task automatic send_lookup(logic [lac_pkg::KEY_W-1:0] key, logic [lac_pkg::SRC_W-1:0] src,
                             logic [lac_pkg::NEED_W-1:0] need);
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.key <= key;
    req.source_offset <= src;
    req.byte_count <= need;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_rsp.push_back(predict_lookup(key, src, need));
    recent_keys.push_back(key);
    if (recent_keys.size() > 48) void'(recent_keys.pop_front());
  endtask

  // Receiver: stall at random, or hold off entirely while hold_cycles runs down.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk) begin
    lac_pkg::rsp_t e;
    if (rst_n && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result, status %0d slot %0d", rsp.status, rsp.slot);
        err_cnt++;
      end else begin
        e = pending_rsp.pop_front();
        check_field("status", 32'(e.status), 32'(rsp.status));
        check_field("slot", 32'(e.slot), 32'(rsp.slot));
        check_field("entry_offset", 32'(e.entry_offset), 32'(rsp.entry_offset));
        check_field("entry_bytes", 32'(e.entry_bytes), 32'(rsp.entry_bytes));
        check_field("fetch_source", e.fetch_source, rsp.fetch_source);
        check_field("compacted", 32'(e.compacted), 32'(rsp.compacted));
        check_field("cleared", 32'(e.cleared), 32'(rsp.cleared));
        check_field("arena_used", 32'(e.arena_used), 32'(rsp.arena_used));
        check_field("hit_total", e.hit_total, rsp.hit_total);
        check_field("miss_total", e.miss_total, rsp.miss_total);
        check_field("evict_total", e.evict_total, rsp.evict_total);
      end
    end
  end

  function automatic logic [lac_pkg::NEED_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 65) return lac_pkg::NEED_W'($urandom_range(1, 200));
    if (r < 82) return lac_pkg::NEED_W'($urandom_range(201, 4095));
    if (r < 87) return lac_pkg::NEED_W'(lac_pkg::BUDGET_BYTES);
    if (r < 92) return '0;
    return lac_pkg::NEED_W'($urandom_range(lac_pkg::BUDGET_BYTES + 1, 65535));
  endfunction

  function automatic logic [lac_pkg::KEY_W-1:0] pick_key();
    if (recent_keys.size() > 0 && $urandom_range(99) < 55)
      return recent_keys[$urandom_range(recent_keys.size() - 1)];
    if ($urandom_range(3) == 0) return lac_pkg::KEY_W'($urandom_range(40));
    return lac_pkg::KEY_W'($urandom);
  endfunction

  // Extremes of every field, rejects, hits and arena overflow.
  task automatic test_directed();
    send_lookup('0, '0, 16'd1);
    send_lookup('0, 32'hFFFF_FFFF, 16'd1);
    send_lookup({lac_pkg::KEY_W{1'b1}}, 32'hFFFF_FFFF, 16'd0);
    send_lookup({lac_pkg::KEY_W{1'b1}}, 32'hA5A5_5A5A, 16'hFFFF);
    send_lookup(25'h1000000, 32'h1234_5678, lac_pkg::NEED_W'(lac_pkg::BUDGET_BYTES + 1));
    send_lookup({lac_pkg::KEY_W{1'b1}}, 32'h5A5A_A5A5, 16'd100);
    send_lookup({lac_pkg::KEY_W{1'b1}}, 32'h0, 16'd7);
    send_lookup(25'h0AAAAAA, 32'h1, lac_pkg::NEED_W'(lac_pkg::BUDGET_BYTES));
    send_lookup(25'h1555555, 32'h2, lac_pkg::NEED_W'(lac_pkg::BUDGET_BYTES));
    send_lookup(25'h0000123, 32'h3, 16'd3000);
    send_lookup(25'h0000124, 32'h4, 16'd1500);
    send_lookup(25'h0000123, 32'h5, 16'd9);
    send_lookup(25'h0000125, 32'h6, 16'd2500);
  endtask

  // Fill every slot, then push past the table so the least recent ones go.
  task automatic test_table_eviction();
    for (int i = 0; i < 40; i++)
      send_lookup(lac_pkg::KEY_W'(25'h0100000 + i), $urandom,
                  lac_pkg::NEED_W'($urandom_range(1, 120)));
    for (int i = 0; i < 10; i++)
      send_lookup(lac_pkg::KEY_W'(25'h0100000 + $urandom_range(39)), $urandom, 16'd50);
  endtask

  task automatic test_random(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_lookup(pick_key(), $urandom, pick_size());
  endtask

  // Hold the receiver off long enough that the block backs up its input.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 400;
    for (int i = 0; i < 60; i++)
      send_lookup(pick_key(), $urandom, lac_pkg::NEED_W'($urandom_range(1, 300)));
  endtask

  initial begin
    err_cnt = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    fill = '0;
    age_now = lac_pkg::AGE_W'(1);
    hits = '0;
    misses = '0;
    evicts = '0;
    for (int i = 0; i < lac_pkg::ENTRIES; i++) begin
      tbl_key[i] = '0; tbl_valid[i] = 1'b0; tbl_off[i] = '0;
      tbl_size[i] = '0; tbl_age[i] = '0;
    end
    rst_n = 1'b0;
    req.valid = 1'b0;
    req.key = '0;
    req.source_offset = '0;
    req.byte_count = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_eviction();
    test_random(450, 0, 0);
    test_random(450, 47, 0);
    test_backpressure();
    test_random(450, 0, 47);
    test_random(450, 21, 21);
    idle_pct = 0;
    stall_pct = 0;
    req.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #200ms;
    $display("tb: errors");
    $finish;
  end

endmodule
